>>> design/scl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_pkg
// shared widths, codes, types and helper functions of the column line center
// ---------------------------------------------------------------------------
package scl_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 4;
	localparam int COLOR_W    = 8;
	localparam int DIST_W     = 10;
	localparam int POINT_W    = 16;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int CNT_W      = COORD_BITS + 1;
	localparam int SUM_W      = 2 * COORD_BITS;
	localparam int QUOT_W     = COORD_BITS + FRAC_BITS;
	localparam int DVD_W      = 2 * COORD_BITS + FRAC_BITS;
	localparam int REM_W      = CNT_W;
	localparam int STEP_W     = $clog2(QUOT_W + 1);

	typedef logic [COLOR_W-1:0]    color_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_W-1:0]     dist_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [QUOT_W-1:0]     quot_t;
	typedef logic [DVD_W-1:0]      dvd_t;
	typedef logic [REM_W-1:0]      rem_t;
	typedef logic [STEP_W-1:0]     step_t;
	typedef logic [POINT_W-1:0]    point_t;
	typedef logic [MODE_W-1:0]     mode_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cnt_t  COUNT_CAP  = cnt_t'(1) << COORD_BITS;
	localparam dist_t DIST_RESET = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRACE_RED   = 3'd0,
		REG_TRACE_GREEN = 3'd1,
		REG_TRACE_BLUE  = 3'd2,
		REG_LIMIT_RED   = 3'd3,
		REG_LIMIT_GREEN = 3'd4,
		REG_LIMIT_BLUE  = 3'd5,
		REG_CENTER_MODE = 3'd6
	} cfg_reg_e;

	typedef enum logic [MODE_W-1:0] {
		MODE_LAST     = 2'd0,
		MODE_CENTROID = 2'd1,
		MODE_FIRST    = 2'd2
	} center_mode_e;

	typedef struct packed {
		logic acc_en;
		logic clear_col;
		logic div_start;
		logic div_src_y;
		logic cap_x;
		logic cap_y;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic use_div;
		logic div_done;
	} dp_status_t;

	function automatic color_t abs_diff(color_t a, color_t b);
		return (a > b) ? color_t'(a - b) : color_t'(b - a);
	endfunction

	function automatic point_t to_point(quot_t v);
		logic [QUOT_W+POINT_W-1:0] w;
		w = {{POINT_W{1'b0}}, v};
		return w[POINT_W-1:0];
	endfunction

	function automatic point_t coord_fixed(coord_t c);
		quot_t q;
		q = quot_t'(c) << FRAC_BITS;
		return to_point(q);
	endfunction

endpackage

>>> design/scl_pix_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_pix_if
// pixel stream channel: color, coordinates and column end marker
// ---------------------------------------------------------------------------
interface scl_pix_if;
	logic            valid;
	logic            ready;
	scl_pkg::color_t pix_red;
	scl_pkg::color_t pix_green;
	scl_pkg::color_t pix_blue;
	scl_pkg::coord_t x_pos;
	scl_pkg::coord_t y_pos;
	logic            column_end;

	modport source (output valid, pix_red, pix_green, pix_blue, x_pos, y_pos, column_end,
		input ready);
	modport sink (input valid, pix_red, pix_green, pix_blue, x_pos, y_pos, column_end,
		output ready);
endinterface

>>> design/scl_pt_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_pt_if
// result channel: chosen point in fixed point and found flag
// ---------------------------------------------------------------------------
interface scl_pt_if;
	logic            valid;
	logic            ready;
	scl_pkg::point_t point_x;
	scl_pkg::point_t point_y;
	logic            found;

	modport source (output valid, point_x, point_y, found, input ready);
	modport sink (input valid, point_x, point_y, found, output ready);
endinterface

>>> design/scl_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_cfg_if
// register write channel: register index and write data
// ---------------------------------------------------------------------------
interface scl_cfg_if;
	logic               valid;
	logic               ready;
	scl_pkg::cfg_idx_t  index;
	scl_pkg::cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/scl_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_div
// restoring divider, one quotient bit per cycle, quotient known to fit
// ---------------------------------------------------------------------------
module scl_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  scl_pkg::dvd_t   dividend,
	input  scl_pkg::cnt_t   divisor,
	output logic            done,
	output scl_pkg::quot_t  quotient
);

	logic                  busy_q;
	logic                  done_q;
	scl_pkg::step_t        step_q;
	scl_pkg::rem_t         rem_q;
	scl_pkg::quot_t        quo_q;
	scl_pkg::cnt_t         dsr_q;
	logic [scl_pkg::REM_W:0] trial;
	logic                  ge;

	always_comb begin
		trial = {rem_q, quo_q[scl_pkg::QUOT_W-1]};
		ge    = trial >= {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= scl_pkg::step_t'(step_q + 1'b1);
			if (step_q == scl_pkg::step_t'(scl_pkg::QUOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= scl_pkg::rem_t'(dividend >> scl_pkg::QUOT_W);
			quo_q <= dividend[scl_pkg::QUOT_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? scl_pkg::rem_t'(trial - {1'b0, dsr_q}) : scl_pkg::rem_t'(trial);
			quo_q <= {quo_q[scl_pkg::QUOT_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/scl_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_dp
// datapath: registers, color match, best distance tracking, centroid, result
// ---------------------------------------------------------------------------
module scl_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  scl_pkg::ctrl_cmd_t  cmd,
	output scl_pkg::dp_status_t status,
	input  logic                cfg_we,
	input  scl_pkg::cfg_idx_t   cfg_index,
	input  scl_pkg::cfg_data_t  cfg_data,
	input  scl_pkg::color_t     pix_red,
	input  scl_pkg::color_t     pix_green,
	input  scl_pkg::color_t     pix_blue,
	input  scl_pkg::coord_t     x_pos,
	input  scl_pkg::coord_t     y_pos,
	output scl_pkg::point_t     point_x,
	output scl_pkg::point_t     point_y,
	output logic                found
);

	scl_pkg::color_t trace_red_q, trace_green_q, trace_blue_q;
	scl_pkg::color_t limit_red_q, limit_green_q, limit_blue_q;
	scl_pkg::mode_t  center_mode_q;

	logic            seen_q, stopped_q, started_q;
	scl_pkg::dist_t  best_dist_q;
	scl_pkg::cnt_t   best_cnt_q;
	scl_pkg::sum_t   sum_x_q, sum_y_q;
	scl_pkg::coord_t first_x_q, first_y_q, last_x_q, last_y_q;
	scl_pkg::coord_t start_x_q, start_y_q;
	scl_pkg::quot_t  cent_x_q, cent_y_q;
	scl_pkg::point_t point_x_q, point_y_q;
	logic            found_q;

	scl_pkg::color_t dr, dg, db;
	scl_pkg::dist_t  dist_sum;
	logic            match;
	logic            is_lt;
	logic            is_eq;
	logic            cnt_full;
	logic            centroid_mode;
	scl_pkg::dvd_t   dvd_x, dvd_y, dvd;
	logic            div_done;
	scl_pkg::quot_t  quotient;

	always_comb begin
		dr       = scl_pkg::abs_diff(pix_red, trace_red_q);
		dg       = scl_pkg::abs_diff(pix_green, trace_green_q);
		db       = scl_pkg::abs_diff(pix_blue, trace_blue_q);
		match    = (dr <= limit_red_q) && (dg <= limit_green_q) && (db <= limit_blue_q);
		dist_sum = scl_pkg::dist_t'(dr) + scl_pkg::dist_t'(dg) + scl_pkg::dist_t'(db);
		is_lt    = dist_sum < best_dist_q;
		is_eq    = dist_sum == best_dist_q;
		cnt_full = best_cnt_q == scl_pkg::COUNT_CAP;
		centroid_mode = (center_mode_q != scl_pkg::MODE_LAST) &&
			(center_mode_q != scl_pkg::MODE_FIRST);
		dvd_x    = (scl_pkg::dvd_t'(sum_x_q) << scl_pkg::FRAC_BITS) +
			scl_pkg::dvd_t'(best_cnt_q >> 1);
		dvd_y    = (scl_pkg::dvd_t'(sum_y_q) << scl_pkg::FRAC_BITS) +
			scl_pkg::dvd_t'(best_cnt_q >> 1);
		dvd      = cmd.div_src_y ? dvd_y : dvd_x;
	end

	scl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (best_cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.use_div  = (best_cnt_q != '0) && centroid_mode;
	assign status.div_done = div_done;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trace_red_q   <= '0;
			trace_green_q <= '0;
			trace_blue_q  <= '0;
			limit_red_q   <= 8'd128;
			limit_green_q <= 8'd128;
			limit_blue_q  <= 8'd128;
			center_mode_q <= scl_pkg::MODE_CENTROID;
		end else if (cfg_we) begin
			case (cfg_index)
				scl_pkg::REG_TRACE_RED:   trace_red_q   <= cfg_data;
				scl_pkg::REG_TRACE_GREEN: trace_green_q <= cfg_data;
				scl_pkg::REG_TRACE_BLUE:  trace_blue_q  <= cfg_data;
				scl_pkg::REG_LIMIT_RED:   limit_red_q   <= cfg_data;
				scl_pkg::REG_LIMIT_GREEN: limit_green_q <= cfg_data;
				scl_pkg::REG_LIMIT_BLUE:  limit_blue_q  <= cfg_data;
				scl_pkg::REG_CENTER_MODE: center_mode_q <= cfg_data[scl_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// column control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			stopped_q   <= 1'b0;
			started_q   <= 1'b0;
			best_dist_q <= scl_pkg::DIST_RESET;
			best_cnt_q  <= '0;
		end else if (cmd.clear_col) begin
			seen_q      <= 1'b0;
			stopped_q   <= 1'b0;
			started_q   <= 1'b0;
			best_dist_q <= scl_pkg::DIST_RESET;
			best_cnt_q  <= '0;
		end else if (cmd.acc_en) begin
			started_q <= 1'b1;
			if (!stopped_q) begin
				if (!match) begin
					if (seen_q) begin
						stopped_q <= 1'b1;
					end
				end else begin
					seen_q <= 1'b1;
					if (is_lt) begin
						best_dist_q <= dist_sum;
						best_cnt_q  <= scl_pkg::cnt_t'(1);
					end else if (is_eq && !cnt_full) begin
						best_cnt_q <= scl_pkg::cnt_t'(best_cnt_q + 1'b1);
					end
				end
			end
		end
	end

	// column payload
	always_ff @(posedge clk) begin
		if (cmd.acc_en) begin
			if (!started_q) begin
				start_x_q <= x_pos;
				start_y_q <= y_pos;
			end
			if (!stopped_q && match) begin
				if (is_lt) begin
					sum_x_q   <= scl_pkg::sum_t'(x_pos);
					sum_y_q   <= scl_pkg::sum_t'(y_pos);
					first_x_q <= x_pos;
					first_y_q <= y_pos;
					last_x_q  <= x_pos;
					last_y_q  <= y_pos;
				end else if (is_eq) begin
					last_x_q <= x_pos;
					last_y_q <= y_pos;
					if (!cnt_full) begin
						sum_x_q <= sum_x_q + scl_pkg::sum_t'(x_pos);
						sum_y_q <= sum_y_q + scl_pkg::sum_t'(y_pos);
					end
				end
			end
		end
		if (cmd.cap_x) begin
			cent_x_q <= quotient;
		end
		if (cmd.cap_y) begin
			cent_y_q <= quotient;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (best_cnt_q == '0) begin
				point_x_q <= scl_pkg::coord_fixed(start_x_q);
				point_y_q <= scl_pkg::coord_fixed(start_y_q);
				found_q   <= 1'b0;
			end else if (center_mode_q == scl_pkg::MODE_LAST) begin
				point_x_q <= scl_pkg::coord_fixed(last_x_q);
				point_y_q <= scl_pkg::coord_fixed(last_y_q);
				found_q   <= 1'b1;
			end else if (center_mode_q == scl_pkg::MODE_FIRST) begin
				point_x_q <= scl_pkg::coord_fixed(first_x_q);
				point_y_q <= scl_pkg::coord_fixed(first_y_q);
				found_q   <= 1'b1;
			end else begin
				point_x_q <= scl_pkg::to_point(cent_x_q);
				point_y_q <= scl_pkg::to_point(cent_y_q);
				found_q   <= 1'b1;
			end
		end
	end

	assign point_x = point_x_q;
	assign point_y = point_y_q;
	assign found   = found_q;

endmodule

>>> design/scl_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scl_ctrl
// controller: pixel intake, column finish, centroid sequencing, result slot
// ---------------------------------------------------------------------------
module scl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_end,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output scl_pkg::ctrl_cmd_t  cmd,
	input  scl_pkg::dp_status_t status
);

	typedef enum logic [4:0] {
		S_SCAN = 5'b00001,
		S_FIN  = 5'b00010,
		S_DIVX = 5'b00100,
		S_DIVY = 5'b01000,
		S_LOAD = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   in_acc;
	logic   slot_free;

	always_comb begin
		in_ready  = state_q == S_SCAN;
		in_acc    = in_valid && in_ready;
		slot_free = !out_valid_q || out_ready;
		state_d   = state_q;
		cmd       = '0;
		case (state_q)
			S_SCAN: begin
				cmd.acc_en = in_acc;
				if (in_acc && in_end) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.use_div) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVX;
				end else begin
					state_d = S_LOAD;
				end
			end
			S_DIVX: begin
				if (status.div_done) begin
					cmd.cap_x     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_src_y = 1'b1;
					state_d       = S_DIVY;
				end
			end
			S_DIVY: begin
				if (status.div_done) begin
					cmd.cap_y = 1'b1;
					state_d   = S_LOAD;
				end
			end
			S_LOAD: begin
				if (slot_free) begin
					cmd.out_load  = 1'b1;
					cmd.clear_col = 1'b1;
					state_d       = S_SCAN;
				end
			end
			default: begin
				state_d = S_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SCAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_load_shows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

	a_no_accum_while_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.acc_en && cmd.clear_col))
		else $error("pixel accumulated during column clear");

	a_end_goes_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_end) |=> (state_q == S_FIN && !in_ready))
		else $error("column end not followed by finish");

	a_div_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !status.div_done)
		else $error("divider done right after start");
`endif

endmodule

>>> design/scan_column_line_center_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scan_column_line_center_core
// finds the center of a colored trace line along one scan column of pixels
// ---------------------------------------------------------------------------
// channel  direction  transaction carries
// pix      in         pix_red, pix_green, pix_blue, x_pos, y_pos, column_end
// pt       out        point_x, point_y, found (one per column)
// cfg      in         index, data (register write, always ready)
//
// one pixel per cycle while a column is scanned
// after column_end the result passes S_FIN and S_LOAD for last, first or
// no match; for the centroid S_DIVX and S_DIVY lie between, run by the
// shared one-bit-per-cycle divider for x then y
// pixels are held off from column_end until the result enters the output
// register; a stalled result holds only the next column's finish
// arst_n clears control state and loads register defaults
// ---------------------------------------------------------------------------
module scan_column_line_center_core (
	input  logic      clk,
	input  logic      arst_n,
	scl_pix_if.sink   pix,
	scl_pt_if.source  pt,
	scl_cfg_if.sink   cfg
);

	scl_pkg::ctrl_cmd_t  cmd;
	scl_pkg::dp_status_t status;

	assign cfg.ready = 1'b1;

	scl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_end    (pix.column_end),
		.in_ready  (pix.ready),
		.out_valid (pt.valid),
		.out_ready (pt.ready),
		.cmd       (cmd),
		.status    (status)
	);

	scl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.pix_red   (pix.pix_red),
		.pix_green (pix.pix_green),
		.pix_blue  (pix.pix_blue),
		.x_pos     (pix.x_pos),
		.y_pos     (pix.y_pos),
		.point_x   (pt.point_x),
		.point_y   (pt.point_y),
		.found     (pt.found)
	);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for scan_column_line_center_core
// ---------------------------------------------------------------------------
// pixel columns are queued by the stimulus process and fed by a clocked
// driver; every accepted pixel goes through a local line center predictor
// and each accepted point is checked against the oldest predicted point.
// covers directed edge columns, all center modes, random well-formed and
// noisy columns under random idling on both channels, and a long output
// stall that backs the block up into its pixel input
// ---------------------------------------------------------------------------
module testbench;
	import scl_pkg::*;

	typedef struct packed {
		color_t red;
		color_t green;
		color_t blue;
		coord_t x;
		coord_t y;
		logic   column_end;
	} pixel_t;

	typedef struct packed {
		point_t px;
		point_t py;
		logic   found;
	} center_point_t;

	localparam cfg_idx_t SPARE_INDEX = 3'd7;
	localparam int DRAIN_CYCLES = 2 * (COORD_BITS + FRAC_BITS + 1) + 8;

	logic clk;
	logic arst_n;

	scl_pix_if pix_ch ();
	scl_pt_if  pt_ch ();
	scl_cfg_if cfg_ch ();

	scan_column_line_center_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.pt     (pt_ch),
		.cfg    (cfg_ch)
	);

	// register copies
	color_t trace_r, trace_g, trace_b;
	color_t lim_r, lim_g, lim_b;
	mode_t  center_sel;

	// column state of the predictor
	logic   col_seen, col_stopped, col_started;
	dist_t  best_dist;
	cnt_t   best_cnt;
	sum_t   acc_x, acc_y;
	coord_t first_x, first_y, last_x, last_y, origin_x, origin_y;

	pixel_t        pixel_backlog[$];
	center_point_t expected_points[$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  receiver_stall;
	bit  pix_fired;
	int  error_count;
	int  pixels_accepted;
	int  points_checked;
	int  columns_queued;
	int  random_items;
	int  reg_writes;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#20_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	task automatic clear_column_state();
		col_seen    = 1'b0;
		col_stopped = 1'b0;
		col_started = 1'b0;
		best_dist   = DIST_RESET;
		best_cnt    = '0;
		acc_x       = '0;
		acc_y       = '0;
		first_x     = '0;
		first_y     = '0;
		last_x      = '0;
		last_y      = '0;
		origin_x    = '0;
		origin_y    = '0;
	endtask

	function automatic point_t centroid_fixed(sum_t total, cnt_t count);
		longint unsigned num;
		num = (longint'(total) << FRAC_BITS) + longint'(count >> 1);
		return point_t'(num / longint'(count));
	endfunction

	task automatic trace_center_step(pixel_t p);
		color_t        dr, dg, db;
		dist_t         dsum;
		logic          hit;
		center_point_t res;
		if (!col_started) begin
			origin_x    = p.x;
			origin_y    = p.y;
			col_started = 1'b1;
		end
		if (!col_stopped) begin
			dr   = (p.red > trace_r) ? p.red - trace_r : trace_r - p.red;
			dg   = (p.green > trace_g) ? p.green - trace_g : trace_g - p.green;
			db   = (p.blue > trace_b) ? p.blue - trace_b : trace_b - p.blue;
			hit  = (dr <= lim_r) && (dg <= lim_g) && (db <= lim_b);
			dsum = dist_t'(dr) + dist_t'(dg) + dist_t'(db);
			if (!hit) begin
				if (col_seen)
					col_stopped = 1'b1;
			end else begin
				col_seen = 1'b1;
				if (dsum < best_dist) begin
					best_dist = dsum;
					best_cnt  = cnt_t'(1);
					acc_x     = sum_t'(p.x);
					acc_y     = sum_t'(p.y);
					first_x   = p.x;
					first_y   = p.y;
					last_x    = p.x;
					last_y    = p.y;
				end else if (dsum == best_dist) begin
					last_x = p.x;
					last_y = p.y;
					if (best_cnt < COUNT_CAP) begin
						best_cnt = best_cnt + 1'b1;
						acc_x    = acc_x + sum_t'(p.x);
						acc_y    = acc_y + sum_t'(p.y);
					end
				end
			end
		end
		if (p.column_end) begin
			if (best_cnt == '0) begin
				res.px    = point_t'({origin_x, FRAC_BITS'(0)});
				res.py    = point_t'({origin_y, FRAC_BITS'(0)});
				res.found = 1'b0;
			end else if (center_sel == MODE_LAST) begin
				res.px    = point_t'({last_x, FRAC_BITS'(0)});
				res.py    = point_t'({last_y, FRAC_BITS'(0)});
				res.found = 1'b1;
			end else if (center_sel == MODE_FIRST) begin
				res.px    = point_t'({first_x, FRAC_BITS'(0)});
				res.py    = point_t'({first_y, FRAC_BITS'(0)});
				res.found = 1'b1;
			end else begin
				res.px    = centroid_fixed(acc_x, best_cnt);
				res.py    = centroid_fixed(acc_y, best_cnt);
				res.found = 1'b1;
			end
			expected_points.push_back(res);
			clear_column_state();
		end
	endtask

	// pixel driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix_ch.valid || pix_fired) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pixel_t p;
					p = pixel_backlog.pop_front();
					pix_ch.pix_red    <= p.red;
					pix_ch.pix_green  <= p.green;
					pix_ch.pix_blue   <= p.blue;
					pix_ch.x_pos      <= p.x;
					pix_ch.y_pos      <= p.y;
					pix_ch.column_end <= p.column_end;
					pix_ch.valid      <= 1'b1;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// accepted pixels feed the predictor
	always @(posedge clk) begin
		pixel_t p;
		pix_fired <= pix_ch.valid && pix_ch.ready;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			p.red        = pix_ch.pix_red;
			p.green      = pix_ch.pix_green;
			p.blue       = pix_ch.pix_blue;
			p.x          = pix_ch.x_pos;
			p.y          = pix_ch.y_pos;
			p.column_end = pix_ch.column_end;
			trace_center_step(p);
			pixels_accepted++;
		end
	end

	// point receiver
	always @(negedge clk) begin
		if (receiver_stall)
			pt_ch.ready <= 1'b0;
		else
			pt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// point checker
	always @(posedge clk) begin
		center_point_t want;
		if (arst_n && pt_ch.valid && pt_ch.ready) begin
			points_checked++;
			if (expected_points.size() == 0) begin
				error_count++;
				if (error_count < 50)
					$display("%0t: unexpected point x=%h y=%h found=%b", $time,
						pt_ch.point_x, pt_ch.point_y, pt_ch.found);
			end else begin
				want = expected_points.pop_front();
				if (pt_ch.point_x !== want.px) begin
					error_count++;
					if (error_count < 50)
						$display("%0t: point_x expected %h actual %h", $time,
							want.px, pt_ch.point_x);
				end
				if (pt_ch.point_y !== want.py) begin
					error_count++;
					if (error_count < 50)
						$display("%0t: point_y expected %h actual %h", $time,
							want.py, pt_ch.point_y);
				end
				if (pt_ch.found !== want.found) begin
					error_count++;
					if (error_count < 50)
						$display("%0t: found expected %b actual %b", $time,
							want.found, pt_ch.found);
				end
			end
		end
	end

	task automatic write_register(cfg_idx_t index, cfg_data_t value);
		@(negedge clk);
		cfg_ch.index <= index;
		cfg_ch.data  <= value;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (index)
			REG_TRACE_RED:   trace_r = value;
			REG_TRACE_GREEN: trace_g = value;
			REG_TRACE_BLUE:  trace_b = value;
			REG_LIMIT_RED:   lim_r = value;
			REG_LIMIT_GREEN: lim_g = value;
			REG_LIMIT_BLUE:  lim_b = value;
			REG_CENTER_MODE: center_sel = mode_t'(value);
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_pixel(int r, int g, int b, int x, int y, bit last);
		pixel_t p;
		p.red        = color_t'(r);
		p.green      = color_t'(g);
		p.blue       = color_t'(b);
		p.x          = coord_t'(x);
		p.y          = coord_t'(y);
		p.column_end = last;
		pixel_backlog.push_back(p);
		if (last)
			columns_queued++;
	endtask

	task automatic drain_columns();
		do
			@(negedge clk);
		while (pixel_backlog.size() != 0 || pix_ch.valid || expected_points.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic color_t near_value(color_t t, color_t lim);
		int d;
		int v;
		if ($urandom_range(9) < 7)
			d = $urandom_range(1, 0);
		else
			d = $urandom_range(int'(lim), 0);
		if (d > int'(lim))
			d = int'(lim);
		v = $urandom_range(1) ? int'(t) + d : int'(t) - d;
		if (v > 255)
			v = int'(t) - d;
		if (v < 0)
			v = int'(t) + d;
		if (v > 255)
			v = 255;
		return color_t'(v);
	endfunction

	function automatic color_t far_value(color_t t, color_t lim);
		int hi_lo;
		int lo_hi;
		hi_lo = int'(t) + int'(lim) + 1;
		lo_hi = int'(t) - int'(lim) - 1;
		if (hi_lo <= 255 && (lo_hi < 0 || $urandom_range(1)))
			return color_t'($urandom_range(255, hi_lo));
		else if (lo_hi >= 0)
			return color_t'($urandom_range(lo_hi, 0));
		return color_t'($urandom);
	endfunction

	task automatic queue_column();
		int     len, lead, run, shape, ch;
		bit     hit, scatter;
		coord_t x0, y0;
		pixel_t p;
		len     = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(8, 1);
		shape   = $urandom_range(9);
		lead    = $urandom_range(len / 3, 0);
		run     = $urandom_range(len - lead, 1);
		scatter = ($urandom_range(9) < 3);
		x0      = coord_t'($urandom);
		y0      = coord_t'($urandom);
		for (int i = 0; i < len; i++) begin
			if (shape < 7) begin
				if (i < lead)
					hit = 1'b0;
				else if (i < lead + run)
					hit = 1'b1;
				else if (i == lead + run)
					hit = 1'b0;
				else
					hit = 1'($urandom_range(1));
			end else if (shape < 9) begin
				hit = 1'($urandom_range(1));
			end else begin
				hit = 1'b0;
			end
			if (hit) begin
				p.red   = near_value(trace_r, lim_r);
				p.green = near_value(trace_g, lim_g);
				p.blue  = near_value(trace_b, lim_b);
			end else begin
				p.red   = color_t'($urandom);
				p.green = color_t'($urandom);
				p.blue  = color_t'($urandom);
				ch      = $urandom_range(2);
				if (ch == 0)
					p.red = far_value(trace_r, lim_r);
				else if (ch == 1)
					p.green = far_value(trace_g, lim_g);
				else
					p.blue = far_value(trace_b, lim_b);
			end
			p.x          = scatter ? coord_t'($urandom) : x0;
			p.y          = coord_t'(y0 + i);
			p.column_end = (i == len - 1);
			pixel_backlog.push_back(p);
		end
		columns_queued++;
		random_items += len;
	endtask

	function automatic cfg_data_t pick_trace();
		case ($urandom_range(5))
			0: return cfg_data_t'(0);
			1: return cfg_data_t'(255);
			default: return cfg_data_t'($urandom);
		endcase
	endfunction

	function automatic cfg_data_t pick_limit();
		case ($urandom_range(5))
			0: return cfg_data_t'(0);
			1: return cfg_data_t'(255);
			2: return cfg_data_t'($urandom_range(8, 0));
			default: return cfg_data_t'($urandom);
		endcase
	endfunction

	task automatic randomize_settings();
		write_register(REG_TRACE_RED, pick_trace());
		write_register(REG_TRACE_GREEN, pick_trace());
		write_register(REG_TRACE_BLUE, pick_trace());
		write_register(REG_LIMIT_RED, pick_limit());
		write_register(REG_LIMIT_GREEN, pick_limit());
		write_register(REG_LIMIT_BLUE, pick_limit());
		write_register(REG_CENTER_MODE, cfg_data_t'($urandom));
	endtask

	initial begin
		int phase_items;
		arst_n            = 1'b0;
		pix_ch.valid      = 1'b0;
		pix_ch.pix_red    = '0;
		pix_ch.pix_green  = '0;
		pix_ch.pix_blue   = '0;
		pix_ch.x_pos      = '0;
		pix_ch.y_pos      = '0;
		pix_ch.column_end = 1'b0;
		pt_ch.ready       = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		pix_fired         = 1'b0;
		receiver_stall    = 1'b0;
		send_idle_pct     = 35;
		recv_idle_pct     = 69;
		error_count       = 0;
		pixels_accepted   = 0;
		points_checked    = 0;
		columns_queued    = 0;
		random_items      = 0;
		reg_writes        = 0;
		trace_r           = '0;
		trace_g           = '0;
		trace_b           = '0;
		lim_r             = 8'd128;
		lim_g             = 8'd128;
		lim_b             = 8'd128;
		center_sel        = MODE_CENTROID;
		clear_column_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: single-pixel columns, stop after match, no match
		queue_pixel(255, 255, 255, 4095, 4095, 1);
		queue_pixel(0, 0, 0, 0, 0, 1);
		queue_pixel(200, 0, 0, 100, 10, 0);
		queue_pixel(3, 0, 0, 100, 11, 0);
		queue_pixel(1, 0, 0, 100, 12, 0);
		queue_pixel(0, 1, 0, 100, 14, 0);
		queue_pixel(128, 128, 128, 100, 15, 0);
		queue_pixel(129, 0, 0, 100, 16, 0);
		queue_pixel(0, 0, 0, 100, 17, 0);
		queue_pixel(0, 0, 0, 100, 18, 1);
		queue_pixel(255, 0, 0, 7, 1, 0);
		queue_pixel(0, 129, 0, 8, 2, 0);
		queue_pixel(0, 0, 255, 9, 3, 1);
		queue_pixel(0, 0, 0, 3, 0, 0);
		queue_pixel(0, 0, 0, 3, 0, 0);
		queue_pixel(0, 0, 0, 3, 2, 1);
		drain_columns();

		// exact red, any green, narrow blue; last, first and the spare mode code
		write_register(REG_TRACE_RED, 8'd255);
		write_register(REG_TRACE_GREEN, 8'd0);
		write_register(REG_TRACE_BLUE, 8'd128);
		write_register(REG_LIMIT_RED, 8'd0);
		write_register(REG_LIMIT_GREEN, 8'd255);
		write_register(REG_LIMIT_BLUE, 8'd3);
		write_register(SPARE_INDEX, 8'hA5);
		for (int m = 0; m < 3; m++) begin
			if (m == 0)
				write_register(REG_CENTER_MODE, cfg_data_t'(MODE_LAST));
			else if (m == 1)
				write_register(REG_CENTER_MODE, {6'b111111, MODE_FIRST});
			else
				write_register(REG_CENTER_MODE, 8'h03);
			queue_pixel(255, 17, 128, 2048, 5, 0);
			queue_pixel(255, 0, 128, 2048, 6, 0);
			queue_pixel(255, 255, 131, 2048, 7, 0);
			queue_pixel(255, 0, 128, 2049, 9, 0);
			queue_pixel(254, 0, 128, 2048, 10, 1);
			drain_columns();
		end

		// random columns, three idling profiles with several settings each
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 69 : 0;
			recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 35 : 0;
			for (int s = 0; s < 3; s++) begin
				randomize_settings();
				phase_items = random_items;
				while (random_items - phase_items < 40)
					queue_column();
				drain_columns();
			end
		end

		// long output stall while columns keep coming
		randomize_settings();
		fork
			begin
				receiver_stall = 1'b1;
				repeat (300) @(posedge clk);
				receiver_stall = 1'b0;
			end
		join_none
		repeat (10) queue_column();
		drain_columns();

		$display("summary: %0d pixels in %0d columns, %0d points checked, %0d register writes",
			pixels_accepted, columns_queued, points_checked, reg_writes);
		$display("summary: all mode codes, empty and stopped columns, output backpressure");
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

>>> files.f
design/scl_pkg.sv
design/scl_pix_if.sv
design/scl_pt_if.sv
design/scl_cfg_if.sv
design/scl_div.sv
design/scl_dp.sv
design/scl_ctrl.sv
design/scan_column_line_center_core.sv
sim/testbench.sv
